// ===== hdl/tccr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell color resolver package
// Shared types and constants: register layout, mode and attribute bits, the
// per-cell control bundle and the repair indices.
// ----------------------------------------------------------------------------
package tccr_pkg;

	localparam int RGB_W  = 24;
	localparam int PAIR_W = 2 * RGB_W;
	localparam int IDX_W  = 8;
	localparam int ATTR_W = 7;
	localparam int OVR_W  = 3;
	localparam int MODE_W = 8;
	localparam int CFG_IDX_W = 3;

	// Operation codes
	localparam logic OP_RESOLVE = 1'b0;
	localparam logic OP_PAL_WRITE = 1'b1;

	// Mode enable bits
	localparam int MODE_ANSI      = 0;
	localparam int MODE_BOLD      = 1;
	localparam int MODE_BLINK     = 2;
	localparam int MODE_UNDERLINE = 3;
	localparam int MODE_URL       = 4;
	localparam int MODE_REVERSE   = 5;
	localparam int MODE_TEXTFIX   = 6;
	localparam int MODE_NORMALBG  = 7;

	// Cell attribute bits
	localparam int ATTR_BOLD      = 0;
	localparam int ATTR_BLINK     = 1;
	localparam int ATTR_UNDERLINE = 2;
	localparam int ATTR_URL       = 3;
	localparam int ATTR_REVERSE   = 4;
	localparam int ATTR_FG_EXP    = 5;
	localparam int ATTR_BG_EXP    = 6;

	// Override bits
	localparam int OVR_REVERSE = 0;
	localparam int OVR_FG      = 1;
	localparam int OVR_BG      = 2;

	// Palette indices that get the same-color repair
	localparam logic [IDX_W-1:0] FIX_BLACK  = 8'd0;
	localparam logic [IDX_W-1:0] FIX_WHITE  = 8'd7;
	localparam logic [IDX_W-1:0] FIX_BRIGHT = 8'd15;

	// Register reset values
	localparam logic [MODE_W-1:0] MODE_RST      = 8'h01;
	localparam logic [PAIR_W-1:0] NORMAL_RST    = 48'h000000FFFFFF;
	localparam logic [PAIR_W-1:0] BOLD_RST      = 48'h0000FFFFFFFF;
	localparam logic [PAIR_W-1:0] BLINK_RST     = 48'hFF0000FFFFFF;
	localparam logic [PAIR_W-1:0] UNDERLINE_RST = 48'hFF00FFFFFFFF;
	localparam logic [PAIR_W-1:0] LINK_RST      = 48'h00FF00FFFFFF;
	localparam logic [PAIR_W-1:0] REVERSE_RST   = 48'hFFFFFF000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_NORMAL    = 3'd1,
		REG_BOLD      = 3'd2,
		REG_BLINK     = 3'd3,
		REG_UNDERLINE = 3'd4,
		REG_LINK      = 3'd5,
		REG_REVERSE   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [PAIR_W-1:0] normal;
		logic [PAIR_W-1:0] bold;
		logic [PAIR_W-1:0] blink;
		logic [PAIR_W-1:0] underline;
		logic [PAIR_W-1:0] link;
		logic [PAIR_W-1:0] reverse;
	} cfg_t;

	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [IDX_W-1:0]  fg_index;
		logic [IDX_W-1:0]  bg_index;
		logic              rev;
		logic [OVR_W-1:0]  ovr;
		logic [RGB_W-1:0]  ovr_fg;
		logic [RGB_W-1:0]  ovr_bg;
	} cell_t;

endpackage

// ===== hdl/tccr_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell color resolve logic
// Picks the attribute pair, applies reverse, explicit palette colors, the
// same-color repair and the highlight override for one cell.
// ----------------------------------------------------------------------------
module tccr_resolve
	import tccr_pkg::*;
(
	input  cfg_t             cfg,
	input  cell_t            cur_cell,
	input  logic [RGB_W-1:0] pal_fg,
	input  logic [RGB_W-1:0] pal_bg,
	output logic [RGB_W-1:0] fg_rgb,
	output logic [RGB_W-1:0] bg_rgb
);

	logic              have;
	logic [PAIR_W-1:0] pr;
	logic [RGB_W-1:0]  back;
	logic [RGB_W-1:0]  fg_base, bg_base;
	logic [RGB_W-1:0]  fg_exp, bg_exp;
	logic [RGB_W-1:0]  fg_fix, bg_fix;
	logic              ansi, fexp, bexp, fix;
	logic [PAIR_W-1:0] fix_pair;

	assign ansi = cfg.mode[MODE_ANSI];
	assign fexp = ansi && cur_cell.attr[ATTR_FG_EXP];
	assign bexp = ansi && cur_cell.attr[ATTR_BG_EXP];

	// Select the attribute pair by priority
	always_comb begin
		have = 1'b1;
		pr   = cfg.normal;
		if (cfg.mode[MODE_BLINK] && cur_cell.attr[ATTR_BLINK]) begin
			pr = cfg.blink;
		end else if (cfg.mode[MODE_BOLD] && cur_cell.attr[ATTR_BOLD]) begin
			pr = cfg.bold;
		end else if (cfg.mode[MODE_UNDERLINE] && cur_cell.attr[ATTR_UNDERLINE]) begin
			pr = cfg.underline;
		end else if (cfg.mode[MODE_URL] && cur_cell.attr[ATTR_URL]) begin
			pr = cfg.link;
		end else begin
			have = 1'b0;
		end
	end

	assign back = cfg.mode[MODE_NORMALBG] ? cfg.normal[RGB_W-1:0] : pr[RGB_W-1:0];

	// Base colors, swapped under reverse; with no attribute pair and reverse mode on, the reverse pair is used
	always_comb begin
		if (!have) begin
			if (!cur_cell.rev) begin
				fg_base = cfg.normal[PAIR_W-1:RGB_W];
				bg_base = cfg.normal[RGB_W-1:0];
			end else if (!cfg.mode[MODE_REVERSE]) begin
				fg_base = cfg.normal[RGB_W-1:0];
				bg_base = cfg.normal[PAIR_W-1:RGB_W];
			end else begin
				fg_base = cfg.reverse[PAIR_W-1:RGB_W];
				bg_base = cfg.reverse[RGB_W-1:0];
			end
		end else if (!cur_cell.rev) begin
			fg_base = pr[PAIR_W-1:RGB_W];
			bg_base = back;
		end else begin
			fg_base = back;
			bg_base = pr[PAIR_W-1:RGB_W];
		end
	end

	// Apply explicit palette colors
	always_comb begin
		fg_exp = fg_base;
		bg_exp = bg_base;
		if (fexp) begin
			if (!cur_cell.rev) fg_exp = pal_fg;
			else               bg_exp = pal_fg;
		end
		if (bexp) begin
			if (!cur_cell.rev) bg_exp = pal_bg;
			else               fg_exp = pal_bg;
		end
	end

	// Repair same-color text on the basic black and white indices
	assign fix = cfg.mode[MODE_TEXTFIX] && fexp && bexp
		&& (cur_cell.fg_index == cur_cell.bg_index)
		&& ((cur_cell.fg_index == FIX_BLACK) || (cur_cell.fg_index == FIX_WHITE)
		|| (cur_cell.fg_index == FIX_BRIGHT));
	assign fix_pair = cur_cell.rev ? cfg.reverse : cfg.normal;
	assign fg_fix   = fix ? fix_pair[PAIR_W-1:RGB_W] : fg_exp;
	assign bg_fix   = fix ? fix_pair[RGB_W-1:0] : bg_exp;

	// Override colors win last
	always_comb begin
		fg_rgb = fg_fix;
		bg_rgb = bg_fix;
		if (cur_cell.ovr[OVR_FG]) begin
			if (cur_cell.rev) bg_rgb = cur_cell.ovr_fg;
			else              fg_rgb = cur_cell.ovr_fg;
		end
		if (cur_cell.ovr[OVR_BG]) begin
			if (cur_cell.rev) fg_rgb = cur_cell.ovr_bg;
			else              bg_rgb = cur_cell.ovr_bg;
		end
	end

endmodule

// ===== hdl/terminal_cell_color_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal cell color resolver
// Resolves 24-bit foreground and background colors of one text cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake. With
//   op = write the item stores palette_rgb in palette entry palette_addr and
//   gives no result; with op = resolve it gives one result on the output
//   channel (out_valid/out_ready) holding fg_rgb and bg_rgb.
//   Pipeline: stage 1 reads the palette at fg_index and bg_index from a
//   256 x 24 memory with two registered read ports; stage 2 resolves the
//   colors into the output register.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the single write port and the read stage of the palette memory. A write
//   followed by a read of the same entry in the next cycle sees the new value.
//   Stall: when out_ready is low and the output register is full, that
//   register holds, stage 1 holds its read data, and in_ready drops once
//   stage 1 is occupied. Reset clears the pipeline and loads the register
//   defaults; palette contents are undefined until written. Configuration
//   writes (cfg_write, cfg_index, cfg_data) take effect at once and must be
//   made while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module terminal_cell_color_resolver
	import tccr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAIR_W-1:0]    cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [ATTR_W-1:0]    attr_flags,
	input  logic [IDX_W-1:0]     fg_index,
	input  logic [IDX_W-1:0]     bg_index,
	input  logic                 selected,
	input  logic                 screen_reverse,
	input  logic [OVR_W-1:0]     override_flags,
	input  logic [RGB_W-1:0]     override_fg,
	input  logic [RGB_W-1:0]     override_bg,
	input  logic [IDX_W-1:0]     palette_addr,
	input  logic [RGB_W-1:0]     palette_rgb,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RGB_W-1:0]     fg_rgb,
	output logic [RGB_W-1:0]     bg_rgb
);

	cfg_t             cfg_q;
	logic [RGB_W-1:0] palette_mem [2**IDX_W];
	logic [RGB_W-1:0] pal_fg_s1, pal_bg_s1;
	cell_t            cell_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic [RGB_W-1:0] fg_q, bg_q;
	logic [RGB_W-1:0] fg_res, bg_res;
	logic             out_free, adv_s1, in_acc, rd_acc, wr_acc;

	// Handshake and stage advance
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_acc   = in_valid && in_ready;
	assign rd_acc   = in_acc && (op == OP_RESOLVE);
	assign wr_acc   = in_acc && (op == OP_PAL_WRITE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_RST;
			cfg_q.normal    <= NORMAL_RST;
			cfg_q.bold      <= BOLD_RST;
			cfg_q.blink     <= BLINK_RST;
			cfg_q.underline <= UNDERLINE_RST;
			cfg_q.link      <= LINK_RST;
			cfg_q.reverse   <= REVERSE_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:      cfg_q.mode      <= cfg_data[MODE_W-1:0];
				REG_NORMAL:    cfg_q.normal    <= cfg_data;
				REG_BOLD:      cfg_q.bold      <= cfg_data;
				REG_BLINK:     cfg_q.blink     <= cfg_data;
				REG_UNDERLINE: cfg_q.underline <= cfg_data;
				REG_LINK:      cfg_q.link      <= cfg_data;
				REG_REVERSE:   cfg_q.reverse   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Palette memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			palette_mem[palette_addr] <= palette_rgb;
		end
		if (rd_acc) begin
			pal_fg_s1 <= palette_mem[fg_index];
			pal_bg_s1 <= palette_mem[bg_index];
		end
	end

	// Stage 1 cell fields
	always_ff @(posedge clk) begin
		if (rd_acc) begin
			cell_s1.attr     <= attr_flags;
			cell_s1.fg_index <= fg_index;
			cell_s1.bg_index <= bg_index;
			cell_s1.rev      <= selected ^ attr_flags[ATTR_REVERSE] ^ screen_reverse
				^ override_flags[OVR_REVERSE];
			cell_s1.ovr      <= override_flags;
			cell_s1.ovr_fg   <= override_fg;
			cell_s1.ovr_bg   <= override_bg;
		end
	end

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rd_acc;
		end
	end

	tccr_resolve u_resolve (
		.cfg      (cfg_q),
		.cur_cell (cell_s1),
		.pal_fg   (pal_fg_s1),
		.pal_bg   (pal_bg_s1),
		.fg_rgb   (fg_res),
		.bg_rgb   (bg_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fg_q <= fg_res;
			bg_q <= bg_res;
		end
	end

	assign out_valid = out_valid_q;
	assign fg_rgb    = fg_q;
	assign bg_rgb    = bg_q;

	// Checks
	a_resolve_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |=> valid_s1)
		else $error("accepted resolve item did not reach stage 1");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_acc && !valid_s1) |=> !valid_s1)
		else $error("palette write produced a pipeline entry");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(pal_fg_s1) && $stable(pal_bg_s1)))
		else $error("stalled stage 1 lost its read data");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

endmodule
